[rtl/bsa_pkg.sv]
// Shared types and constants for the bitmap slot allocator.
// No dependencies; imported by bsa_fit, bitmap_slot_allocator and bsa_checker.
package bsa_pkg;

  localparam int SLOTS        = 64;
  localparam int MAX_RUN      = 63;
  localparam int OFFSET_PAGES = 16;
  localparam int MARK_W       = 7;   // {start mark, run length in slots}

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_NOT_ALLOC= 2'd3
  } status_t;

  typedef enum logic [3:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SCAN,
    FSM_CHECK,
    FSM_NEW,
    FSM_MARK_CHK,
    FSM_FREE_WR,
    FSM_RESP
  } fsm_t;

  function automatic logic [63:0] run_mask(input logic [5:0] n);
    run_mask = (64'd1 << n) - 64'd1;
  endfunction

endpackage

[rtl/bsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bsa_fit.sv]
// First-fit search for a free run of n slots in one 64-slot page bitmap.
// Depends on bsa_pkg.
module bsa_fit
  import bsa_pkg::*;
(
  input  logic [63:0] bitmap,
  input  logic [5:0]  n,
  output logic        found,
  output logic [5:0]  slot
);

  logic [63:0] fits;
  logic [63:0] mask;

  assign mask = run_mask(n);

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      fits[s] = ((bitmap >> s) & mask) == 64'd0 && (7'(s) + {1'b0, n} <= 7'd64);
    end
  end

  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (fits[s]) begin
        found = 1'b1;
        slot  = 6'(s);
      end
    end
  end

endmodule

[rtl/bitmap_slot_allocator.sv]
// Bitmap slot allocator: first-fit allocation of 64-byte slots in 4 KiB pages.
// Allocate scans live pages in order for a first fit, reading each page's bitmap from the
// bitmap RAM, then falls back to the lowest dead page; free and query read the start mark.
// One beat at a time: in_tready returns once the result is registered.
// Reset (rst_n, synchronous): control cleared, then a clearing pass over all PAGES*64
// start-mark RAM entries (1024 at default) before in_tready rises.
// Depends on bsa_pkg, bsa_ram, bsa_fit.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int PAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [11:0] req_length, [27:12] block_offset
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] granted_offset, [27:16] block_bytes
  output logic [1:0]  out_tuser,  // [1:0] status
  // config (APB-style)
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int LIM   = (PAGES < OFFSET_PAGES) ? PAGES : OFFSET_PAGES;
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;   // bitmap RAM address
  localparam int MDEP  = PAGES * SLOTS;
  localparam int MAW   = $clog2(MDEP);                       // mark RAM address
  localparam int CW    = $clog2(LIM + 1);                    // scan counter

  // state
  fsm_t              state_r, state_nxt;
  logic [CW-1:0]     pg_r, pg_nxt;
  logic [5:0]        n_r, n_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [PW-1:0]     page_r, page_nxt;
  logic [5:0]        slot_r, slot_nxt;
  logic [1:0]        res_st_r, res_st_nxt;
  logic [15:0]       res_off_r, res_off_nxt;
  logic [11:0]       res_bytes_r, res_bytes_nxt;
  logic [4:0]        limit_r, limit_nxt;
  logic [PAGES-1:0]  live_r, live_nxt;
  logic [MAW-1:0]    clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;
  logic [1:0]        out_user_r, out_user_nxt;

  // memory ports
  logic              bm_we;
  logic [PW-1:0]     bm_waddr, bm_raddr;
  logic [63:0]       bm_wdata, bm_rdata;
  logic              mk_we;
  logic [MAW-1:0]    mk_waddr, mk_raddr;
  logic [MARK_W-1:0] mk_wdata, mk_rdata;

  // search
  logic              fit_found;
  logic [5:0]        fit_slot;
  logic [4:0]        usable;
  logic              new_found;
  logic [PW-1:0]     new_pg;
  logic [PW-1:0]     pidx;

  // decode of the incoming beat
  logic [11:0]       in_len;
  logic [15:0]       in_off;
  logic [12:0]       len_sum;
  logic [6:0]        n_full;
  logic [3:0]        off_pg;
  logic              off_ok;
  logic              cfg_wr;
  logic [63:0]       freed;

  // slot bitmaps, one 64-bit row per page
  bsa_ram #(.WIDTH(64), .DEPTH(PAGES)) u_bm_ram (
    .clk, .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  // start marks and run lengths, one entry per page/slot
  bsa_ram #(.WIDTH(MARK_W), .DEPTH(MDEP)) u_mk_ram (
    .clk, .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
    .raddr(mk_raddr), .rdata(mk_rdata)
  );

  bsa_fit u_fit (.bitmap(bm_rdata), .n(n_r), .found(fit_found), .slot(fit_slot));

  assign pidx    = PW'(pg_r);
  assign usable  = (limit_r < 5'(LIM)) ? limit_r : 5'(LIM);
  assign in_len  = in_tdata[11:0];
  assign in_off  = in_tdata[27:12];
  assign len_sum = {1'b0, in_len} + 13'd63;
  assign n_full  = len_sum[12:6];
  assign off_pg  = in_off[15:12];
  assign off_ok  = (in_off[5:0] == 6'd0) && ({1'b0, off_pg} < 5'(LIM))
                   && live_r[PW'(off_pg)];
  assign freed   = bm_rdata & ~(run_mask(n_r) << slot_r);

  // lowest dead page under the usable limit
  always_comb begin
    new_found = 1'b0;
    new_pg    = '0;
    for (int p = LIM - 1; p >= 0; p--) begin
      if (!live_r[p] && 5'(p) < usable) begin
        new_found = 1'b1;
        new_pg    = PW'(p);
      end
    end
  end

  // config port: single register, always ready
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 3'd0);
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {27'd0, limit_r} : 32'd0;
  assign limit_nxt  = cfg_wr ? cfg_pwdata[4:0] : limit_r;

  assign in_tready  = (state_r == FSM_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    state_nxt     = state_r;
    pg_nxt        = pg_r;
    n_nxt         = n_r;
    cmd_nxt       = cmd_r;
    page_nxt      = page_r;
    slot_nxt      = slot_r;
    res_st_nxt    = res_st_r;
    res_off_nxt   = res_off_r;
    res_bytes_nxt = res_bytes_r;
    live_nxt      = live_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    bm_we    = 1'b0;
    bm_waddr = pidx;
    bm_wdata = '0;
    bm_raddr = pidx;
    mk_we    = 1'b0;
    mk_waddr = clr_r;
    mk_wdata = '0;
    mk_raddr = MAW'({PW'(off_pg), in_off[11:6]});

    case (state_r)
      FSM_CLEAR: begin
        mk_we   = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == MAW'(MDEP - 1)) begin
          state_nxt = FSM_IDLE;
        end
      end

      FSM_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt       = cmd_t'(in_tuser);
          res_off_nxt   = '0;
          res_bytes_nxt = '0;
          res_st_nxt    = ST_NOT_ALLOC;
          state_nxt     = FSM_RESP;
          case (cmd_t'(in_tuser))
            CMD_ALLOC: begin
              if (n_full == 7'd0 || n_full > 7'(MAX_RUN)) begin
                res_st_nxt = ST_BAD_LEN;
              end else begin
                n_nxt     = n_full[5:0];
                pg_nxt    = '0;
                state_nxt = FSM_SCAN;
              end
            end
            CMD_FREE, CMD_QUERY: begin
              page_nxt = PW'(off_pg);
              slot_nxt = in_off[11:6];
              if (off_ok) begin
                state_nxt = FSM_MARK_CHK;
              end
            end
            default: ;
          endcase
        end
      end

      FSM_SCAN: begin
        if (pg_r == CW'(LIM)) begin
          state_nxt = FSM_NEW;
        end else if (live_r[pidx]) begin
          state_nxt = FSM_CHECK;
        end else begin
          pg_nxt = pg_r + 1'b1;
        end
      end

      FSM_CHECK: begin
        if (fit_found) begin
          bm_we         = 1'b1;
          bm_wdata      = bm_rdata | (run_mask(n_r) << fit_slot);
          mk_we         = 1'b1;
          mk_waddr      = MAW'({pidx, fit_slot});
          mk_wdata      = {1'b1, n_r};
          res_st_nxt    = ST_OK;
          res_off_nxt   = {4'(pg_r), fit_slot, 6'd0};
          res_bytes_nxt = {n_r, 6'd0};
          state_nxt     = FSM_RESP;
        end else begin
          pg_nxt    = pg_r + 1'b1;
          state_nxt = FSM_SCAN;
        end
      end

      FSM_NEW: begin
        state_nxt = FSM_RESP;
        if (new_found) begin
          live_nxt[new_pg] = 1'b1;
          bm_we         = 1'b1;
          bm_waddr      = new_pg;
          bm_wdata      = 64'd1 | (run_mask(n_r) << 1);
          mk_we         = 1'b1;
          mk_waddr      = MAW'({new_pg, 6'd1});
          mk_wdata      = {1'b1, n_r};
          res_st_nxt    = ST_OK;
          res_off_nxt   = {4'(new_pg), 6'd1, 6'd0};
          res_bytes_nxt = {n_r, 6'd0};
        end else begin
          res_st_nxt = ST_NO_SPACE;
        end
      end

      FSM_MARK_CHK: begin
        bm_raddr  = page_r;
        state_nxt = FSM_RESP;
        if (mk_rdata[6]) begin
          n_nxt         = mk_rdata[5:0];
          res_st_nxt    = ST_OK;
          res_bytes_nxt = {mk_rdata[5:0], 6'd0};
          if (cmd_r == CMD_FREE) begin
            state_nxt = FSM_FREE_WR;
          end
        end
      end

      FSM_FREE_WR: begin
        bm_we     = 1'b1;
        bm_waddr  = page_r;
        bm_wdata  = freed;
        mk_we     = 1'b1;
        mk_waddr  = MAW'({page_r, slot_r});
        mk_wdata  = {1'b0, n_r};
        // page back to header-only: retire it
        if (freed == 64'd1) begin
          live_nxt[page_r] = 1'b0;
        end
        state_nxt = FSM_RESP;
      end

      FSM_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, res_bytes_r, res_off_r};
          out_user_nxt  = res_st_r;
          state_nxt     = FSM_IDLE;
        end
      end

      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_CLEAR;
      clr_r       <= '0;
      live_r      <= '0;
      limit_r     <= 5'd16;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      live_r      <= live_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pg_r        <= pg_nxt;
    n_r         <= n_nxt;
    cmd_r       <= cmd_nxt;
    page_r      <= page_nxt;
    slot_r      <= slot_nxt;
    res_st_r    <= res_st_nxt;
    res_off_r   <= res_off_nxt;
    res_bytes_r <= res_bytes_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

endmodule

[rtl/bsa_checker.sv]
// Port-level checks for bitmap_slot_allocator, bound to the top level.
// Depends on bsa_pkg.
module bsa_checker
  import bsa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !in_tready)
    else $error("beat signals active after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == 32'd0)
    else $error("error beat carries data");

  a_grant_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OK && out_tdata[15:0] != 16'd0
      |-> out_tdata[5:0] == 6'd0 && out_tdata[11:6] != 6'd0 && out_tdata[27:16] != 12'd0)
    else $error("granted offset hits a header or lacks a length");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);
